/* rtl/drvt_pkg.sv */
package drvt_pkg;

    localparam int FIELD_BITS    = 21;
    localparam int STEP_BITS     = 18;
    localparam int SHIFT_BITS    = 20;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 21;

    localparam int VOLT_BITS_DEF = 21;
    localparam int MAX_STEPS_DEF = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_MIN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_MAX   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_STEP  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRACE_EN   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SHIFT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SHIFT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOOT_LOGIC = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOOT_SRAM  = 3'd7;

    localparam logic [FIELD_BITS-1:0] RST_GRID_MIN   = 21'd600000;
    localparam logic [FIELD_BITS-1:0] RST_GRID_MAX   = 21'd1400000;
    localparam logic [STEP_BITS-1:0]  RST_GRID_STEP  = 18'd6250;
    localparam logic                  RST_TRACE_EN   = 1'b1;
    localparam logic [SHIFT_BITS-1:0] RST_MIN_SHIFT  = 20'd100000;
    localparam logic [SHIFT_BITS-1:0] RST_MAX_SHIFT  = 20'd200000;
    localparam logic [FIELD_BITS-1:0] RST_BOOT_LOGIC = 21'd1000000;
    localparam logic [FIELD_BITS-1:0] RST_BOOT_SRAM  = 21'd1100000;

    localparam logic RAIL_SRAM  = 1'b0;
    localparam logic RAIL_LOGIC = 1'b1;

    typedef struct packed {
        logic load;
        logic top_go;
        logic top_take;
        logic cand_a;
        logic cand_b;
        logic classify;
        logic take_div;
        logic emit;
        logic emit_b;
        logic emit_off;
    } t_cmd;

    typedef struct packed {
        logic trace_on;
        logic at_target;
        logic div_busy;
        logic fail;
        logic b_last;
        logic out_free;
    } t_status;

endpackage

/* rtl/drvt_rem.sv */
module drvt_rem import drvt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [FIELD_BITS-1:0] i_num,
    input  logic [STEP_BITS-1:0]  i_den,
    output logic                  o_busy,
    output logic [STEP_BITS-1:0]  o_rem
);

    localparam int CNT_BITS = $clog2(FIELD_BITS);

    logic                  r_busy;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [FIELD_BITS-1:0] r_num;
    logic [STEP_BITS-1:0]  r_rem;
    logic [STEP_BITS:0]    trial;
    logic [STEP_BITS:0]    den_x;

    assign trial = {r_rem, r_num[FIELD_BITS-1]};
    assign den_x = {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(FIELD_BITS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // restoring remainder, one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (trial >= den_x) begin
                r_rem <= STEP_BITS'(trial - den_x);
            end else begin
                r_rem <= STEP_BITS'(trial);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

/* rtl/drvt_dp.sv */
module drvt_dp import drvt_pkg::*; #(
    parameter int VOLT_BITS = VOLT_BITS_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic [FIELD_BITS-1:0]    i_target_logic_volt,
    input  logic [FIELD_BITS-1:0]    i_target_sram_volt,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_cmd_stall,
    output logic                     o_cmd_valid,
    output logic                     o_rail_select,
    output logic [FIELD_BITS-1:0]    o_write_volt,
    output logic                     o_error_flag,
    output logic                     o_last_write
);

    localparam int CW = ((VOLT_BITS > FIELD_BITS) ? VOLT_BITS : FIELD_BITS) + 3;
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam logic [FIELD_BITS-1:0] FMASK = (VOLT_BITS >= FIELD_BITS) ?
        {FIELD_BITS{1'b1}} : FIELD_BITS'((64'd1 << VOLT_BITS) - 64'd1);

    // configuration
    logic [FIELD_BITS-1:0] r_grid_min;
    logic [FIELD_BITS-1:0] r_grid_max;
    logic [STEP_BITS-1:0]  r_grid_step;
    logic                  r_trace_en;
    logic [SHIFT_BITS-1:0] r_min_shift;
    logic [SHIFT_BITS-1:0] r_max_shift;

    // rail state
    logic [VOLT_BITS-1:0]  r_logic_now;
    logic [VOLT_BITS-1:0]  r_sram_now;
    logic [FIELD_BITS-1:0] r_tl;
    logic [FIELD_BITS-1:0] r_ts;

    // run state
    logic signed [CW-1:0]  r_pl;
    logic signed [CW-1:0]  r_ps;
    logic signed [CW-1:0]  r_cand;
    logic signed [CW-1:0]  r_res;
    logic signed [CW-1:0]  r_va;
    logic [FIELD_BITS-1:0] r_top;
    logic                  r_ok;
    logic                  r_rise;
    logic                  r_down;
    logic                  r_fail;
    logic                  r_need;
    logic [SW-1:0]         r_step;

    // result register
    logic                  r_out_valid;
    logic                  r_out_rail;
    logic [FIELD_BITS-1:0] r_out_volt;
    logic                  r_out_err;
    logic                  r_out_last;

    logic [STEP_BITS-1:0]  st_eff;
    logic signed [CW-1:0]  tl_s, ts_s, lo_s, top_s, st_s, min_sh_s, max_sh_s;
    logic signed [CW-1:0]  pl_now_s, ps_now_s;
    logic                  rise_c;
    logic signed [CW-1:0]  cand_a_v, cand_b_v;
    logic                  cls_fail, cls_clamp, cls_need;
    logic signed [CW-1:0]  rem_s, res_div;
    logic                  div_start, div_busy;
    logic [FIELD_BITS-1:0] div_num;
    logic [STEP_BITS-1:0]  div_rem;
    logic                  hit, b_last, out_free;

    assign st_eff   = (r_grid_step == '0) ? STEP_BITS'(1) : r_grid_step;
    assign tl_s     = CW'(r_tl);
    assign ts_s     = CW'(r_ts);
    assign lo_s     = CW'(r_grid_min);
    assign top_s    = CW'(r_top);
    assign st_s     = CW'(st_eff);
    assign min_sh_s = CW'(r_min_shift);
    assign max_sh_s = CW'(r_max_shift);
    assign pl_now_s = CW'(r_logic_now);
    assign ps_now_s = CW'(r_sram_now);

    // first write of a step: sram on the way up, logic on the way down
    assign rise_c = r_pl < tl_s;
    always_comb begin
        if (rise_c) begin
            cand_a_v = (ts_s - r_pl < max_sh_s) ? ts_s : r_pl + max_sh_s;
        end else begin
            cand_a_v = (r_ps - tl_s < max_sh_s) ? tl_s : r_ps - max_sh_s;
        end
    end

    always_comb begin
        if (r_rise) begin
            cand_b_v = (ts_s == r_va) ? tl_s : r_va - min_sh_s;
        end else begin
            cand_b_v = (tl_s == r_va) ? ts_s : r_va + min_sh_s;
        end
    end

    // grid rounding: sram rounds down, logic rounds up
    assign cls_fail  = !r_ok || (r_down ? (r_cand < lo_s) : (r_cand > top_s));
    assign cls_clamp = r_down ? (r_cand >= top_s) : (r_cand <= lo_s);
    assign cls_need  = !cls_fail && !cls_clamp;

    assign div_start = i_cmd.top_go || (i_cmd.classify && cls_need);
    assign div_num   = i_cmd.top_go ? (r_grid_max - r_grid_min) :
                                      FIELD_BITS'(r_cand - lo_s);

    drvt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (st_eff),
        .o_busy  (div_busy),
        .o_rem   (div_rem)
    );

    assign rem_s = CW'(div_rem);
    always_comb begin
        if (r_down) begin
            res_div = r_cand - rem_s;
        end else if (div_rem == '0) begin
            res_div = r_cand;
        end else begin
            res_div = r_cand - rem_s + st_s;
        end
    end

    assign hit      = r_rise ? (r_res == tl_s && r_va == ts_s) :
                               (r_va == tl_s && r_res == ts_s);
    assign b_last   = hit || (r_step == SW'(MAX_STEPS - 1));
    assign out_free = !r_out_valid || !i_cmd_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_min  <= RST_GRID_MIN;
            r_grid_max  <= RST_GRID_MAX;
            r_grid_step <= RST_GRID_STEP;
            r_trace_en  <= RST_TRACE_EN;
            r_min_shift <= RST_MIN_SHIFT;
            r_max_shift <= RST_MAX_SHIFT;
            r_logic_now <= VOLT_BITS'(RST_BOOT_LOGIC);
            r_sram_now  <= VOLT_BITS'(RST_BOOT_SRAM);
            r_tl        <= '0;
            r_ts        <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_MIN:   r_grid_min  <= i_cfg_wdata;
                    CFG_GRID_MAX:   r_grid_max  <= i_cfg_wdata;
                    CFG_GRID_STEP:  r_grid_step <= i_cfg_wdata[STEP_BITS-1:0];
                    CFG_TRACE_EN:   r_trace_en  <= i_cfg_wdata[0];
                    CFG_MIN_SHIFT:  r_min_shift <= i_cfg_wdata[SHIFT_BITS-1:0];
                    CFG_MAX_SHIFT:  r_max_shift <= i_cfg_wdata[SHIFT_BITS-1:0];
                    CFG_BOOT_LOGIC: r_logic_now <= VOLT_BITS'(i_cfg_wdata);
                    CFG_BOOT_SRAM:  r_sram_now  <= VOLT_BITS'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_tl   <= i_target_logic_volt & FMASK;
                r_ts   <= i_target_sram_volt & FMASK;
                r_step <= '0;
            end
            if (i_cmd.emit_off) begin
                r_logic_now <= VOLT_BITS'(r_tl);
            end
            if (i_cmd.emit && !r_fail) begin
                if (r_down) begin
                    r_sram_now <= VOLT_BITS'(r_res);
                end else begin
                    r_logic_now <= VOLT_BITS'(r_res);
                end
                if (i_cmd.emit_b) begin
                    r_step <= SW'(r_step + 1'b1);
                end
            end
            if (i_cmd.emit || i_cmd.emit_off) begin
                r_out_valid <= 1'b1;
            end else if (!i_cmd_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pl <= pl_now_s;
            r_ps <= ps_now_s;
        end
        if (i_cmd.top_take) begin
            r_top <= r_grid_max - FIELD_BITS'(div_rem);
            r_ok  <= r_grid_max >= r_grid_min;
        end
        if (i_cmd.cand_a) begin
            r_cand <= cand_a_v;
            r_rise <= rise_c;
            r_down <= rise_c;
        end
        if (i_cmd.cand_b) begin
            r_cand <= cand_b_v;
            r_down <= !r_rise;
        end
        if (i_cmd.classify) begin
            r_fail <= cls_fail;
            r_need <= cls_need;
            r_res  <= r_down ? top_s : lo_s;
        end
        if (i_cmd.take_div && r_need) begin
            r_res <= res_div;
        end
        if (i_cmd.emit) begin
            if (!i_cmd.emit_b) begin
                r_va <= r_res;
            end else if (!r_fail) begin
                if (r_rise) begin
                    r_pl <= r_res;
                end else begin
                    r_ps <= r_res;
                end
            end
            r_out_rail <= r_down ? RAIL_SRAM : RAIL_LOGIC;
            r_out_volt <= r_fail ? '0 : FIELD_BITS'(VOLT_BITS'(r_res));
            r_out_err  <= r_fail;
            r_out_last <= r_fail || (i_cmd.emit_b && b_last);
        end
        if (i_cmd.emit_off) begin
            r_out_rail <= RAIL_LOGIC;
            r_out_volt <= FIELD_BITS'(VOLT_BITS'(r_tl));
            r_out_err  <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    assign o_status.trace_on  = r_trace_en;
    assign o_status.at_target = (pl_now_s == tl_s);
    assign o_status.div_busy  = div_busy;
    assign o_status.fail      = r_fail;
    assign o_status.b_last    = b_last;
    assign o_status.out_free  = out_free;

    assign o_cmd_valid   = r_out_valid;
    assign o_rail_select = r_out_rail;
    assign o_write_volt  = r_out_volt;
    assign o_error_flag  = r_out_err;
    assign o_last_write  = r_out_last;

endmodule

/* rtl/drvt_ctrl.sv */
module drvt_ctrl import drvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_TOP_GO   = 4'd2;
    localparam logic [3:0] S_TOP_WAIT = 4'd3;
    localparam logic [3:0] S_CAND_A   = 4'd4;
    localparam logic [3:0] S_CLS_A    = 4'd5;
    localparam logic [3:0] S_DIV_A    = 4'd6;
    localparam logic [3:0] S_EMIT_A   = 4'd7;
    localparam logic [3:0] S_CAND_B   = 4'd8;
    localparam logic [3:0] S_CLS_B    = 4'd9;
    localparam logic [3:0] S_DIV_B    = 4'd10;
    localparam logic [3:0] S_EMIT_B   = 4'd11;
    localparam logic [3:0] S_EMIT_OFF = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (!i_status.trace_on) begin
                    n_state = S_EMIT_OFF;
                end else if (i_status.at_target) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_TOP_GO;
                end
            end
            S_TOP_GO: begin
                o_cmd.top_go = 1'b1;
                n_state      = S_TOP_WAIT;
            end
            S_TOP_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.top_take = 1'b1;
                    n_state        = S_CAND_A;
                end
            end
            S_CAND_A: begin
                o_cmd.cand_a = 1'b1;
                n_state      = S_CLS_A;
            end
            S_CLS_A: begin
                o_cmd.classify = 1'b1;
                n_state        = S_DIV_A;
            end
            S_DIV_A: begin
                if (!i_status.div_busy) begin
                    o_cmd.take_div = 1'b1;
                    n_state        = S_EMIT_A;
                end
            end
            S_EMIT_A: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.fail ? S_IDLE : S_CAND_B;
                end
            end
            S_CAND_B: begin
                o_cmd.cand_b = 1'b1;
                n_state      = S_CLS_B;
            end
            S_CLS_B: begin
                o_cmd.classify = 1'b1;
                n_state        = S_DIV_B;
            end
            S_DIV_B: begin
                if (!i_status.div_busy) begin
                    o_cmd.take_div = 1'b1;
                    n_state        = S_EMIT_B;
                end
            end
            S_EMIT_B: begin
                if (i_status.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.emit_b = 1'b1;
                    if (i_status.fail || i_status.b_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_CAND_A;
                    end
                end
            end
            S_EMIT_OFF: begin
                if (i_status.out_free) begin
                    o_cmd.emit_off = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/dual_rail_voltage_tracker_core.sv */
// dual rail voltage tracker: turns a target pair (logic rail, sram rail) into an ordered
// run of rail write commands, keeping the sram rail a set margin above the logic rail.
// request channel: i_req_valid / o_req_stall with the two target voltages; one request is
// taken at a time; o_req_stall stays high until its last command reaches the output register.
// command channel: o_cmd_valid / i_cmd_stall, one write per command, o_last_write on the
// final one; an off-grid rounding ends the run with o_error_flag and o_last_write set.
// with tracking off a request gives a single write of the logic target; a request already
// at the logic target with tracking on gives no command and frees the port. otherwise the
// grid top is set up first, then each step makes two writes, at most MAX_STEPS steps per
// request. each rounding runs through a shared bit-serial remainder unit, one bit per cycle
// over 21 bits; a rounding clamped to the grid edge skips the remainder unit.
// a stalled receiver holds the current command in the output register and the run pauses
// before the next write until that command is taken.
// reset (synchronous, active low) loads the default configuration and the boot voltages
// of both rails; writing a boot register also loads that rail's present voltage.
// configuration is to be written only while no request is in progress.
module dual_rail_voltage_tracker_core import drvt_pkg::*; #(
    parameter int VOLT_BITS = VOLT_BITS_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_req_valid,
    output logic                     o_req_stall,
    input  logic [FIELD_BITS-1:0]    i_target_logic_volt,
    input  logic [FIELD_BITS-1:0]    i_target_sram_volt,
    output logic                     o_cmd_valid,
    input  logic                     i_cmd_stall,
    output logic                     o_rail_select,
    output logic [FIELD_BITS-1:0]    o_write_volt,
    output logic                     o_error_flag,
    output logic                     o_last_write
);

    t_cmd    cmd;
    t_status status;

    drvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (o_req_stall)
    );

    drvt_dp #(
        .VOLT_BITS (VOLT_BITS),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_target_logic_volt (i_target_logic_volt),
        .i_target_sram_volt  (i_target_sram_volt),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cmd_stall         (i_cmd_stall),
        .o_cmd_valid         (o_cmd_valid),
        .o_rail_select       (o_rail_select),
        .o_write_volt        (o_write_volt),
        .o_error_flag        (o_error_flag),
        .o_last_write        (o_last_write)
    );

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_error_flag) |-> o_last_write)
        else $error("error command not marked last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_error_flag) |-> (o_write_volt == '0))
        else $error("error command carries a voltage");

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("request port free right after a request");

endmodule

/* dv/dual_rail_voltage_tracker_core_tb.sv */
`timescale 1ns / 1ps

module dual_rail_voltage_tracker_core_tb;
    import drvt_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          HOLD_OFF       = 400;
    localparam int          PHASES         = 6;
    localparam int          PHASE_ITEMS    = 75;
    localparam int unsigned VOLT_TOP       = 2000000;

    typedef struct packed {
        logic                  rail;
        logic [FIELD_BITS-1:0] volt;
        logic                  err;
        logic                  last;
    } t_rail_write;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_kind;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;
    logic                     i_req_valid = 1'b0;
    logic [FIELD_BITS-1:0]    i_target_logic_volt = '0;
    logic [FIELD_BITS-1:0]    i_target_sram_volt = '0;
    logic                     i_cmd_stall = 1'b0;
    logic                     o_req_stall;
    logic                     o_cmd_valid;
    logic                     o_rail_select;
    logic [FIELD_BITS-1:0]    o_write_volt;
    logic                     o_error_flag;
    logic                     o_last_write;

    // tracker state as the block should hold it
    logic [FIELD_BITS-1:0] cfg_grid_min, cfg_grid_max, cfg_boot_logic, cfg_boot_sram;
    logic [STEP_BITS-1:0]  cfg_grid_step;
    logic                  cfg_trace;
    logic [SHIFT_BITS-1:0] cfg_min_shift, cfg_max_shift;
    logic [FIELD_BITS-1:0] rail_logic_now, rail_sram_now;

    t_rail_write expected_writes[$];

    t_stall_kind stall_mode = STALL_LIGHT;
    int hold_request = 0;
    int burst_left = 0;
    int gap_max = 8;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int writes_checked = 0;
    int reg_writes = 0;

    dual_rail_voltage_tracker_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_req_valid         (i_req_valid),
        .o_req_stall         (o_req_stall),
        .i_target_logic_volt (i_target_logic_volt),
        .i_target_sram_volt  (i_target_sram_volt),
        .o_cmd_valid         (o_cmd_valid),
        .i_cmd_stall         (i_cmd_stall),
        .o_rail_select       (o_rail_select),
        .o_write_volt        (o_write_volt),
        .o_error_flag        (o_error_flag),
        .o_last_write        (o_last_write)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void tracker_reset();
        cfg_grid_min   = RST_GRID_MIN;
        cfg_grid_max   = RST_GRID_MAX;
        cfg_grid_step  = RST_GRID_STEP;
        cfg_trace      = RST_TRACE_EN;
        cfg_min_shift  = RST_MIN_SHIFT;
        cfg_max_shift  = RST_MAX_SHIFT;
        cfg_boot_logic = RST_BOOT_LOGIC;
        cfg_boot_sram  = RST_BOOT_SRAM;
        rail_logic_now = RST_BOOT_LOGIC;
        rail_sram_now  = RST_BOOT_SRAM;
    endfunction

    function automatic longint grid_pitch();
        longint st;
        st = cfg_grid_step;
        return (st == 0) ? 1 : st;
    endfunction

    function automatic bit grid_top(output longint top);
        longint lo, hi, st;
        lo = cfg_grid_min;
        hi = cfg_grid_max;
        st = grid_pitch();
        top = 0;
        if (hi < lo) return 1'b0;
        top = lo + ((hi - lo) / st) * st;
        return 1'b1;
    endfunction

    function automatic bit snap_down(input longint v, output longint r);
        longint top, lo, st;
        lo = cfg_grid_min;
        st = grid_pitch();
        r = 0;
        if (!grid_top(top) || v < lo) return 1'b0;
        r = (v >= top) ? top : lo + ((v - lo) / st) * st;
        return 1'b1;
    endfunction

    function automatic bit snap_up(input longint v, output longint r);
        longint top, lo, st;
        lo = cfg_grid_min;
        st = grid_pitch();
        r = 0;
        if (!grid_top(top) || v > top) return 1'b0;
        r = (v <= lo) ? lo : lo + ((v - lo + st - 1) / st) * st;
        return 1'b1;
    endfunction

    function automatic void plan_rail_writes(input logic [FIELD_BITS-1:0] t_logic,
                                             input logic [FIELD_BITS-1:0] t_sram);
        t_rail_write run [0:2*MAX_STEPS_DEF-1];
        longint tl, ts, pl, ps, lo_sh, hi_sh, vs, vp, snapped;
        int n, s, k;
        bit aborted;
        tl = t_logic;
        ts = t_sram;
        pl = rail_logic_now;
        ps = rail_sram_now;
        lo_sh = cfg_min_shift;
        hi_sh = cfg_max_shift;
        n = 0;
        aborted = 1'b0;
        if (!cfg_trace) begin
            expected_writes.push_back('{RAIL_LOGIC, t_logic, 1'b0, 1'b1});
            rail_logic_now = t_logic;
            return;
        end
        if (pl == tl) return;
        for (s = 0; s < MAX_STEPS_DEF; s++) begin
            if (pl < tl) begin
                vs = (ts - pl < hi_sh) ? ts : pl + hi_sh;
                if (!snap_down(vs, snapped)) begin
                    run[n] = '{RAIL_SRAM, '0, 1'b1, 1'b1};
                    n++;
                    aborted = 1'b1;
                    break;
                end
                vs = snapped;
                run[n] = '{RAIL_SRAM, vs[FIELD_BITS-1:0], 1'b0, 1'b0};
                n++;
                rail_sram_now = vs[FIELD_BITS-1:0];
                vp = (ts == vs) ? tl : vs - lo_sh;
                if (!snap_up(vp, snapped)) begin
                    run[n] = '{RAIL_LOGIC, '0, 1'b1, 1'b1};
                    n++;
                    aborted = 1'b1;
                    break;
                end
                vp = snapped;
                run[n] = '{RAIL_LOGIC, vp[FIELD_BITS-1:0], 1'b0, 1'b0};
                n++;
                rail_logic_now = vp[FIELD_BITS-1:0];
                if (vp == tl && vs == ts) break;
                pl = vp;
            end else begin
                vp = (ps - tl < hi_sh) ? tl : ps - hi_sh;
                if (!snap_up(vp, snapped)) begin
                    run[n] = '{RAIL_LOGIC, '0, 1'b1, 1'b1};
                    n++;
                    aborted = 1'b1;
                    break;
                end
                vp = snapped;
                run[n] = '{RAIL_LOGIC, vp[FIELD_BITS-1:0], 1'b0, 1'b0};
                n++;
                rail_logic_now = vp[FIELD_BITS-1:0];
                vs = (tl == vp) ? ts : vp + lo_sh;
                if (!snap_down(vs, snapped)) begin
                    run[n] = '{RAIL_SRAM, '0, 1'b1, 1'b1};
                    n++;
                    aborted = 1'b1;
                    break;
                end
                vs = snapped;
                run[n] = '{RAIL_SRAM, vs[FIELD_BITS-1:0], 1'b0, 1'b0};
                n++;
                rail_sram_now = vs[FIELD_BITS-1:0];
                if (vp == tl && vs == ts) break;
                ps = vs;
            end
        end
        if (!aborted) run[n-1].last = 1'b1;
        for (k = 0; k < n; k++) expected_writes.push_back(run[k]);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : monitor
        t_rail_write want;
        if (i_rst_n && o_cmd_valid && !i_cmd_stall) begin
            writes_checked++;
            if (expected_writes.size() == 0) begin
                report_mismatch("rail write with none pending, volt", 0, o_write_volt);
            end else begin
                want = expected_writes.pop_front();
                if (o_rail_select !== want.rail)
                    report_mismatch("rail_select", want.rail, o_rail_select);
                if (o_write_volt !== want.volt)
                    report_mismatch("write_volt", want.volt, o_write_volt);
                if (o_error_flag !== want.err)
                    report_mismatch("error_flag", want.err, o_error_flag);
                if (o_last_write !== want.last)
                    report_mismatch("last_write", want.last, o_last_write);
            end
        end
        if (i_rst_n && i_req_valid && !o_req_stall)
            plan_rail_writes(i_target_logic_volt, i_target_sram_volt);
        if (!i_rst_n || (o_cmd_valid && !i_cmd_stall) || (i_req_valid && !o_req_stall)
                || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    always @(posedge i_clk) begin : receiver
        int hold_left;
        int tick;
        tick++;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_cmd_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_cmd_stall <= 1'b0;
                STALL_LIGHT: i_cmd_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_cmd_stall <= ($urandom_range(0, 3) != 0);
                default:     i_cmd_stall <= ((tick % 7) < 3);
            endcase
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("dual_rail_voltage_tracker_core: mismatch");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_GRID_MIN:   cfg_grid_min = val[FIELD_BITS-1:0];
            CFG_GRID_MAX:   cfg_grid_max = val[FIELD_BITS-1:0];
            CFG_GRID_STEP:  cfg_grid_step = val[STEP_BITS-1:0];
            CFG_TRACE_EN:   cfg_trace = val[0];
            CFG_MIN_SHIFT:  cfg_min_shift = val[SHIFT_BITS-1:0];
            CFG_MAX_SHIFT:  cfg_max_shift = val[SHIFT_BITS-1:0];
            CFG_BOOT_LOGIC: begin
                cfg_boot_logic = val[FIELD_BITS-1:0];
                rail_logic_now = val[FIELD_BITS-1:0];
            end
            CFG_BOOT_SRAM: begin
                cfg_boot_sram = val[FIELD_BITS-1:0];
                rail_sram_now = val[FIELD_BITS-1:0];
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic apply_settings(input int unsigned gmin, input int unsigned gmax,
                                  input int unsigned gstep, input int unsigned trace,
                                  input int unsigned mins, input int unsigned maxs);
        write_reg(CFG_GRID_MIN, gmin);
        write_reg(CFG_GRID_MAX, gmax);
        write_reg(CFG_GRID_STEP, gstep);
        write_reg(CFG_TRACE_EN, trace);
        write_reg(CFG_MIN_SHIFT, mins);
        write_reg(CFG_MAX_SHIFT, maxs);
    endtask

    task automatic restore_defaults();
        apply_settings(RST_GRID_MIN, RST_GRID_MAX, RST_GRID_STEP, RST_TRACE_EN,
                       RST_MIN_SHIFT, RST_MAX_SHIFT);
    endtask

    task automatic send_targets(input logic [FIELD_BITS-1:0] tl,
                                input logic [FIELD_BITS-1:0] ts);
        i_req_valid <= 1'b1;
        i_target_logic_volt <= tl;
        i_target_sram_volt <= ts;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24)
                                                     : $urandom_range(0, 3);
        end
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_targets();
        longint tl, ts, span, band;
        int kind;
        kind = $urandom_range(0, 19);
        span = (cfg_grid_max > cfg_grid_min) ? cfg_grid_max - cfg_grid_min : 0;
        band = (cfg_max_shift > cfg_min_shift) ? cfg_max_shift - cfg_min_shift : 0;
        if (kind < 13) begin
            tl = cfg_grid_min + $urandom_range(0, 32'(span));
            ts = tl + cfg_min_shift + $urandom_range(0, 32'(band));
        end else if (kind < 15) begin
            tl = rail_logic_now;
            ts = $urandom_range(0, VOLT_TOP);
        end else begin
            tl = $urandom_range(0, VOLT_TOP);
            ts = $urandom_range(0, VOLT_TOP);
        end
        if (tl > VOLT_TOP) tl = VOLT_TOP;
        if (ts > VOLT_TOP) ts = VOLT_TOP;
        send_targets(tl[FIELD_BITS-1:0], ts[FIELD_BITS-1:0]);
    endtask

    task automatic test_reset_defaults();
        send_targets(21'd1000000, 21'd1100000);
        send_targets(21'd1200000, 21'd1300000);
        send_targets(21'd700000, 21'd800000);
        send_targets(21'd0, 21'd0);
        send_targets(21'd2000000, 21'd2000000);
        wait_drained();
    endtask

    task automatic test_tracking_off();
        write_reg(CFG_TRACE_EN, 0);
        send_targets(21'd0, 21'd2000000);
        send_targets(21'd2000000, 21'd0);
        send_targets(21'd1234567, 21'd5);
        wait_drained();
        write_reg(CFG_TRACE_EN, 1);
    endtask

    task automatic test_grid_corners();
        // empty grid
        write_reg(CFG_GRID_MAX, 0);
        send_targets(21'd900000, 21'd1000000);
        wait_drained();
        write_reg(CFG_GRID_MAX, 1400000);
        write_reg(CFG_GRID_STEP, 0);
        send_targets(21'd800000, 21'd900000);
        wait_drained();
        apply_settings(0, 2000000, 200000, 1, 100000, 200000);
        send_targets(21'd1500000, 21'd1650000);
        send_targets(21'd0, 21'd2000000);
        wait_drained();
        // single point grid
        write_reg(CFG_GRID_MIN, 2000000);
        send_targets(21'd100000, 21'd200000);
        wait_drained();
        restore_defaults();
    endtask

    task automatic test_step_limit();
        write_reg(CFG_MIN_SHIFT, 0);
        write_reg(CFG_MAX_SHIFT, 6250);
        send_targets(21'd600000, 21'd600000);
        send_targets(21'd1400000, 21'd1400000);
        wait_drained();
        write_reg(CFG_MIN_SHIFT, 1000000);
        write_reg(CFG_MAX_SHIFT, 0);
        send_targets(21'd900000, 21'd1000000);
        wait_drained();
        restore_defaults();
    endtask

    task automatic test_boot_registers();
        write_reg(CFG_BOOT_LOGIC, 2000000);
        write_reg(CFG_BOOT_SRAM, 0);
        send_targets(21'd900000, 21'd1000000);
        wait_drained();
        write_reg(CFG_BOOT_LOGIC, 0);
        write_reg(CFG_BOOT_SRAM, 2000000);
        send_targets(21'd700000, 21'd800000);
        wait_drained();
        write_reg(CFG_BOOT_LOGIC, RST_BOOT_LOGIC);
        write_reg(CFG_BOOT_SRAM, RST_BOOT_SRAM);
        send_targets(21'd1000000, 21'd1100000);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int i;
        stall_mode = STALL_NONE;
        hold_request = HOLD_OFF;
        burst_left = 12;
        for (i = 0; i < 12; i++) send_random_targets();
        wait_drained();
    endtask

    task automatic test_random_phases();
        int p, i;
        int unsigned gmin, gmax, gstep, mins, maxs;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: restore_defaults();
                1: apply_settings(600000, 1400000, 1, 1, 0, 1000000);
                2: apply_settings(0, 2000000, 200000, 1, 100000, 200000);
                default: begin
                    gmin = $urandom_range(0, 1200000);
                    gmax = ($urandom_range(0, 7) == 0) ? $urandom_range(0, gmin)
                                                      : gmin + $urandom_range(0, 800000);
                    gstep = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 60000);
                    mins = $urandom_range(0, 300000);
                    maxs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, mins)
                                                      : mins + $urandom_range(0, 400000);
                    apply_settings(gmin, gmax, gstep, ($urandom_range(0, 4) != 0), mins,
                                   maxs);
                end
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_BOOT_LOGIC, cfg_grid_min + $urandom_range(0, 400000));
                write_reg(CFG_BOOT_SRAM, rail_logic_now + $urandom_range(0, 300000));
            end
            stall_mode = t_stall_kind'(p % 4);
            gap_max = $urandom_range(1, 30);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2 && p % 2 == 1) wait_drained();
                send_random_targets();
            end
            wait_drained();
        end
    endtask

    initial begin
        tracker_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_tracking_off();
        test_grid_corners();
        test_step_limit();
        test_boot_registers();
        test_backpressure();
        test_random_phases();
        wait_drained();
        if (expected_writes.size() != 0)
            report_mismatch("rail writes never produced", 0, expected_writes.size());
        $display("covered %0d requests and %0d rail writes over %0d register writes",
                 requests_sent, writes_checked, reg_writes);
        $display("grid corners, tracking off, step limit, boot loads and long stalls included");
        if (mismatch_count == 0) begin
            $display("dual_rail_voltage_tracker_core: match");
        end else begin
            $display("dual_rail_voltage_tracker_core: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/drvt_pkg.sv
rtl/drvt_rem.sv
rtl/drvt_dp.sv
rtl/drvt_ctrl.sv
rtl/dual_rail_voltage_tracker_core.sv
dv/dual_rail_voltage_tracker_core_tb.sv
